### design/assert_macros.svh
// Assertion macros for the checker file of the date shifter.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on the rising clock edge, off during reset.
`define DAD_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("date shifter check failed");

// Next-cycle implication, sampled on the rising clock edge, off during reset.
`define DAD_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("date shifter check failed");

`endif

### design/dad_pkg.sv
// Shared types, constants and calendar functions of the date shifter.
package dad_pkg;

  localparam int OFFSET_WIDTH = 17;
  localparam int YEAR_W  = 14;
  localparam int MONTH_W = 4;
  localparam int DAYIN_W = 6;
  localparam int DAY_W   = 5;
  localparam int WDAY_W  = 3;
  localparam int YDAY_W  = 9;

  // Working day count: holds the offset plus a month length, and 366 as a signed value.
  localparam int DW = (OFFSET_WIDTH + 1 > 11) ? OFFSET_WIDTH + 1 : 11;

  localparam int S_YEAR_LSB  = 0;
  localparam int S_MONTH_LSB = S_YEAR_LSB + YEAR_W;
  localparam int S_DAY_LSB   = S_MONTH_LSB + MONTH_W;
  localparam int S_OFF_LSB   = S_DAY_LSB + DAYIN_W;
  localparam int S_FIELDS_W  = S_OFF_LSB + OFFSET_WIDTH;
  localparam int S_DATA_W    = ((S_FIELDS_W + 7) / 8) * 8;

  localparam int M_YEAR_LSB  = 0;
  localparam int M_MONTH_LSB = M_YEAR_LSB + YEAR_W;
  localparam int M_DAY_LSB   = M_MONTH_LSB + MONTH_W;
  localparam int M_WDAY_LSB  = M_DAY_LSB + DAY_W;
  localparam int M_YDAY_LSB  = M_WDAY_LSB + WDAY_W;
  localparam int M_OOR_BIT   = M_YDAY_LSB + YDAY_W;
  localparam int M_FIELDS_W  = M_OOR_BIT + 1;
  localparam int M_DATA_W    = ((M_FIELDS_W + 7) / 8) * 8;

  localparam logic [YEAR_W-1:0]  YEAR_MIN  = 14'd1;
  localparam logic [YEAR_W-1:0]  YEAR_MAX  = 14'd9999;
  localparam logic [YEAR_W-1:0]  YEAR_PAST = 14'd10000;
  localparam logic [4:0]         YEAR_MAX_MOD25 = 5'd24;
  localparam logic [4:0]         YEAR_MIN_MOD25 = 5'd1;

  localparam logic [MONTH_W-1:0] MONTH_JAN = 4'd1;
  localparam logic [MONTH_W-1:0] MONTH_FEB = 4'd2;
  localparam logic [MONTH_W-1:0] MONTH_DEC = 4'd12;
  localparam logic [DAY_W-1:0]   DAY_LAST_DEC = 5'd31;
  localparam logic [8:0]         YEAR_DAYS = 9'd365;

  // floor(y / 25) = (y * 20972) >> 19, exact for y below 2**14.
  localparam logic [14:0] DIV25_MUL   = 15'd20972;
  localparam int          DIV25_SHIFT = 19;
  // floor(s / 7) = (s * 149797) >> 20, exact for s below 2**14.
  localparam logic [17:0] DIV7_MUL    = 18'd149797;
  localparam int          DIV7_SHIFT  = 20;

  typedef enum logic [3:0] {
    ST_IDLE, ST_INIT_Q, ST_INIT_R, ST_CLAMP, ST_STEP,
    ST_SAT, ST_WK_Q, ST_WK_SUM, ST_WK_MOD, ST_DONE
  } ctrl_state_t;

  typedef enum logic [3:0] {
    OP_NONE, OP_LOAD, OP_INIT_Q, OP_INIT_R, OP_CLAMP, OP_STEP,
    OP_SAT, OP_WK_Q, OP_WK_SUM, OP_WK_MOD, OP_OUT
  } dp_op_t;

  typedef struct packed {
    logic settled;   // date fits its month, or the year left the range
    logic out_free;  // output register can take a result this cycle
  } dp_status_t;

  // Gregorian leap rule from the low year bits and the year modulo 25.
  function automatic logic is_leap(input logic [3:0] ylow, input logic [4:0] ymod25);
    logic div25;
    div25 = (ymod25 == 5'd0);
    return ((ylow[1:0] == 2'd0) && !div25) || ((ylow == 4'd0) && div25);
  endfunction

  function automatic logic [4:0] mod25_step(input logic [4:0] r, input logic up);
    logic [4:0] res;
    if (up) begin
      res = (r == 5'd24) ? 5'd0 : r + 5'd1;
    end else begin
      res = (r == 5'd0) ? 5'd24 : r - 5'd1;
    end
    return res;
  endfunction

  function automatic logic [4:0] month_len(input logic [3:0] m, input logic leap);
    logic [4:0] len;
    case (m)
      4'd2:                      len = 5'd28 + {4'd0, leap};
      4'd4, 4'd6, 4'd9, 4'd11:   len = 5'd30;
      default:                   len = 5'd31;
    endcase
    return len;
  endfunction

  // Days in the months before m, common year.
  function automatic logic [8:0] days_before(input logic [3:0] m);
    logic [8:0] n;
    case (m)
      4'd2:    n = 9'd31;
      4'd3:    n = 9'd59;
      4'd4:    n = 9'd90;
      4'd5:    n = 9'd120;
      4'd6:    n = 9'd151;
      4'd7:    n = 9'd181;
      4'd8:    n = 9'd212;
      4'd9:    n = 9'd243;
      4'd10:   n = 9'd273;
      4'd11:   n = 9'd304;
      4'd12:   n = 9'd334;
      default: n = 9'd0;
    endcase
    return n;
  endfunction

  // Month term (13*m + 8) / 5 of the weekday formula, January and February
  // counted as months 13 and 14 of the year before.
  function automatic logic [5:0] month_term(input logic [3:0] m);
    logic [5:0] t;
    case (m)
      4'd1:    t = 6'd35;
      4'd2:    t = 6'd38;
      4'd3:    t = 6'd9;
      4'd4:    t = 6'd12;
      4'd5:    t = 6'd14;
      4'd6:    t = 6'd17;
      4'd7:    t = 6'd19;
      4'd8:    t = 6'd22;
      4'd9:    t = 6'd25;
      4'd10:   t = 6'd27;
      4'd11:   t = 6'd30;
      default: t = 6'd32;
    endcase
    return t;
  endfunction

endpackage

### design/dad_ctrl.sv
// Sequencer of the date shifter: walks the datapath through one request.
module dad_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                s_tvalid,
  output logic                s_tready,
  input  dad_pkg::dp_status_t status,
  output dad_pkg::dp_op_t     op
);
  import dad_pkg::*;

  ctrl_state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    op         = OP_NONE;
    s_tready   = 1'b0;
    case (state)
      ST_IDLE: begin
        s_tready = 1'b1;
        if (s_tvalid) begin
          op         = OP_LOAD;
          state_next = ST_INIT_Q;
        end
      end
      ST_INIT_Q: begin
        op         = OP_INIT_Q;
        state_next = ST_INIT_R;
      end
      ST_INIT_R: begin
        op         = OP_INIT_R;
        state_next = ST_CLAMP;
      end
      ST_CLAMP: begin
        op         = OP_CLAMP;
        state_next = ST_STEP;
      end
      ST_STEP: begin
        if (status.settled) begin
          state_next = ST_SAT;
        end else begin
          op = OP_STEP;
        end
      end
      ST_SAT: begin
        op         = OP_SAT;
        state_next = ST_WK_Q;
      end
      ST_WK_Q: begin
        op         = OP_WK_Q;
        state_next = ST_WK_SUM;
      end
      ST_WK_SUM: begin
        op         = OP_WK_SUM;
        state_next = ST_WK_MOD;
      end
      ST_WK_MOD: begin
        op         = OP_WK_MOD;
        state_next = ST_DONE;
      end
      ST_DONE: begin
        if (status.out_free) begin
          op         = OP_OUT;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule

### design/dad_datapath.sv
// Datapath of the date shifter: date registers, year and month stepping, weekday.
module dad_datapath (
  input  logic                          clk,
  input  logic                          rst,
  input  dad_pkg::dp_op_t               op,
  input  logic [dad_pkg::S_DATA_W-1:0]  s_tdata,
  output dad_pkg::dp_status_t           status,
  output logic                          m_tvalid,
  input  logic                          m_tready,
  output logic [dad_pkg::M_DATA_W-1:0]  m_tdata
);
  import dad_pkg::*;

  logic [YEAR_W-1:0]        y;
  logic [MONTH_W-1:0]       m;
  logic signed [DW-1:0]     d;
  logic [4:0]               r25;
  logic                     flag;
  logic [OFFSET_WIDTH-1:0]  off;
  logic [8:0]               q25;
  logic [13:0]              wsum;
  logic [10:0]              q7;

  logic [YEAR_W-1:0]   year_o;
  logic [MONTH_W-1:0]  month_o;
  logic [DAY_W-1:0]    day_o;
  logic [WDAY_W-1:0]   wday_o;
  logic [YDAY_W-1:0]   yday_o;
  logic                oor_o;

  logic [YEAR_W-1:0]   yin;
  logic [MONTH_W-1:0]  min;
  logic [YEAR_W-1:0]   y_p1, y_m1, yy, mul_src;
  logic [4:0]          r25_p1, r25_m1;
  logic                leap_c, leap_p, leap_m, early;
  logic [4:0]          md, md_prev;
  logic [8:0]          len_fwd, len_bwd;
  logic signed [DW-1:0] md_s, lf_s, lb_s, back_sum, off_s, dcl_s;
  logic [5:0]          dcl;
  logic                fwd, bwd, yr_out;
  logic [28:0]         prod25;
  logic [31:0]         prod7;
  logic [13:0]         wk_rem;
  logic [13:0]         r25_full;

  assign yin = s_tdata[S_YEAR_LSB +: YEAR_W];
  assign min = s_tdata[S_MONTH_LSB +: MONTH_W];

  assign y_p1   = y + 14'd1;
  assign y_m1   = y - 14'd1;
  assign r25_p1 = mod25_step(r25, 1'b1);
  assign r25_m1 = mod25_step(r25, 1'b0);
  assign leap_c = is_leap(y[3:0], r25);
  assign leap_p = is_leap(y_p1[3:0], r25_p1);
  assign leap_m = is_leap(y_m1[3:0], r25_m1);
  assign early  = (m <= MONTH_FEB);

  assign md      = month_len(m, leap_c);
  assign md_prev = month_len(m - 4'd1, leap_c);
  // Twelve months forward from (y, m) cross February of y or of y + 1;
  // twelve months back cross February of y - 1 or of y.
  assign len_fwd = YEAR_DAYS + {8'd0, early ? leap_c : leap_p};
  assign len_bwd = YEAR_DAYS + {8'd0, early ? leap_m : leap_c};

  assign md_s     = $signed({{(DW-5){1'b0}}, md});
  assign lf_s     = $signed({{(DW-9){1'b0}}, len_fwd});
  assign lb_s     = $signed({{(DW-9){1'b0}}, len_bwd});
  assign back_sum = d + lb_s;
  assign off_s    = $signed({{(DW-OFFSET_WIDTH){off[OFFSET_WIDTH-1]}}, off});

  assign fwd    = (d > md_s);
  assign bwd    = d[DW-1] || (d == '0);
  assign yr_out = (y == '0) || (y == YEAR_PAST);

  assign status.settled  = yr_out || (!fwd && !bwd);
  assign status.out_free = !m_tvalid || m_tready;

  // Day clamp to 1..month length.
  always_comb begin
    dcl = d[5:0];
    if (dcl == 6'd0) begin
      dcl = 6'd1;
    end else if (dcl > {1'b0, md}) begin
      dcl = {1'b0, md};
    end
  end
  assign dcl_s = $signed({{(DW-6){1'b0}}, dcl});

  // Shared divide-by-25 multiplier: start year at setup, weekday year later.
  assign yy      = early ? y_m1 : y;
  assign mul_src = (op == OP_INIT_Q) ? y : yy;
  assign prod25  = {15'd0, mul_src} * {14'd0, DIV25_MUL};
  assign prod7   = {18'd0, wsum} * {14'd0, DIV7_MUL};
  assign r25_full = y - ({5'd0, q25} * 14'd25);
  assign wk_rem   = wsum - ({3'd0, q7} * 14'd7);

  always_ff @(posedge clk) begin
    case (op)
      OP_LOAD: begin
        if (yin == '0) begin
          y    <= YEAR_MIN;
          flag <= 1'b1;
        end else if (yin > YEAR_MAX) begin
          y    <= YEAR_MAX;
          flag <= 1'b1;
        end else begin
          y    <= yin;
          flag <= 1'b0;
        end
        if (min == 4'd0) begin
          m <= MONTH_JAN;
        end else if (min > MONTH_DEC) begin
          m <= MONTH_DEC;
        end else begin
          m <= min;
        end
        d   <= $signed({{(DW-DAYIN_W){1'b0}}, s_tdata[S_DAY_LSB +: DAYIN_W]});
        off <= s_tdata[S_OFF_LSB +: OFFSET_WIDTH];
      end
      OP_INIT_Q: begin
        q25 <= prod25[DIV25_SHIFT +: 9];
      end
      OP_INIT_R: begin
        r25 <= r25_full[4:0];
      end
      OP_CLAMP: begin
        d <= dcl_s + off_s;
      end
      OP_STEP: begin
        if (fwd) begin
          if (d > lf_s) begin
            y   <= y_p1;
            r25 <= r25_p1;
            d   <= d - lf_s;
          end else begin
            d <= d - md_s;
            if (m == MONTH_DEC) begin
              m   <= MONTH_JAN;
              y   <= y_p1;
              r25 <= r25_p1;
            end else begin
              m <= m + 4'd1;
            end
          end
        end else if (bwd) begin
          if (back_sum[DW-1] || (back_sum == '0)) begin
            y   <= y_m1;
            r25 <= r25_m1;
            d   <= back_sum;
          end else if (m == MONTH_JAN) begin
            m   <= MONTH_DEC;
            y   <= y_m1;
            r25 <= r25_m1;
            d   <= d + $signed({{(DW-5){1'b0}}, DAY_LAST_DEC});
          end else begin
            m <= m - 4'd1;
            d <= d + $signed({{(DW-5){1'b0}}, md_prev});
          end
        end
      end
      OP_SAT: begin
        if (y == YEAR_PAST) begin
          y    <= YEAR_MAX;
          m    <= MONTH_DEC;
          d    <= $signed({{(DW-5){1'b0}}, DAY_LAST_DEC});
          r25  <= YEAR_MAX_MOD25;
          flag <= 1'b1;
        end else if (y == '0) begin
          y    <= YEAR_MIN;
          m    <= MONTH_JAN;
          d    <= $signed({{(DW-1){1'b0}}, 1'b1});
          r25  <= YEAR_MIN_MOD25;
          flag <= 1'b1;
        end
      end
      OP_WK_Q: begin
        q25 <= prod25[DIV25_SHIFT +: 9];
      end
      OP_WK_SUM: begin
        wsum <= yy + {2'd0, yy[13:2]} - {7'd0, q25[8:2]} + {9'd0, q25[8:4]}
              + {8'd0, month_term(m)} + {9'd0, d[4:0]};
      end
      OP_WK_MOD: begin
        q7 <= prod7[DIV7_SHIFT +: 11];
      end
      OP_OUT: begin
        year_o  <= y;
        month_o <= m;
        day_o   <= d[4:0];
        wday_o  <= wk_rem[2:0];
        yday_o  <= {4'd0, d[4:0]} + days_before(m) + {8'd0, (m > MONTH_FEB) && leap_c};
        oor_o   <= flag;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (op == OP_OUT) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  assign m_tdata = {{(M_DATA_W-M_FIELDS_W){1'b0}}, oor_o, yday_o, wday_o, day_o, month_o, year_o};

endmodule

### design/date_add_days_top.sv
// Top level of the Gregorian date shifter: sequencer plus datapath.
//
//  Channel  Dir  Handshake          Payload (low bit first)
//  -------  ---  -----------------  ----------------------------------------------------
//  s_*      in   s_tvalid/s_tready  year_in 14, month_in 4, day_in 6, day_offset 17 signed
//  m_*      out  m_tvalid/m_tready  year_out 14, month_out 4, day_out 5, weekday 3,
//                                   year_day 9, out_of_range 1
//
// One request is worked at a time. Its run time grows with each whole year and each
// single month stepped, which is bounded by the offset. The year/month stepping
// loop in the datapath does these steps; each year step moves 365 or 366 days.
// Reset is synchronous and active high; it clears the sequencer and the output
// valid flag. A result waits in the output register while the next request is
// taken; the block only stalls at its last step when that register is still full.
module date_add_days_top (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         s_tvalid,
  output logic                         s_tready,
  // year_in[13:0], month_in[17:14], day_in[23:18], day_offset[40:24], zero pad
  input  logic [dad_pkg::S_DATA_W-1:0] s_tdata,
  output logic                         m_tvalid,
  input  logic                         m_tready,
  // year_out[13:0], month_out[17:14], day_out[22:18], weekday[25:23],
  // year_day[34:26], out_of_range[35], zero pad
  output logic [dad_pkg::M_DATA_W-1:0] m_tdata
);
  import dad_pkg::*;

  dp_op_t     op;
  dp_status_t status;

  // The sequencer owns the input handshake and issues one command per cycle.
  dad_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .status   (status),
    .op       (op)
  );

  // The datapath holds the working date and the output register.
  dad_datapath u_dp (
    .clk      (clk),
    .rst      (rst),
    .op       (op),
    .s_tdata  (s_tdata),
    .status   (status),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

endmodule

### design/dad_checker.sv
// Port-level checks of the date shifter, bound to the top level.
`include "assert_macros.svh"

module dad_checker (
  input logic                         clk,
  input logic                         rst,
  input logic                         s_tvalid,
  input logic                         s_tready,
  input logic [dad_pkg::S_DATA_W-1:0] s_tdata,
  input logic                         m_tvalid,
  input logic                         m_tready,
  input logic [dad_pkg::M_DATA_W-1:0] m_tdata
);
  import dad_pkg::*;

  logic [MONTH_W-1:0] mon;
  logic [DAY_W-1:0]   dy;
  logic [WDAY_W-1:0]  wd;
  logic [YDAY_W-1:0]  yd;

  assign mon = m_tdata[M_MONTH_LSB +: MONTH_W];
  assign dy  = m_tdata[M_DAY_LSB +: DAY_W];
  assign wd  = m_tdata[M_WDAY_LSB +: WDAY_W];
  assign yd  = m_tdata[M_YDAY_LSB +: YDAY_W];

  `DAD_ASSERT_NEXT(a_valid_held, m_tvalid && !m_tready, m_tvalid)
  `DAD_ASSERT_NEXT(a_data_held, m_tvalid && !m_tready, $stable(m_tdata))
  `DAD_ASSERT_NEXT(a_busy_after_accept, s_tvalid && s_tready, !s_tready)
  `DAD_ASSERT_NOW(a_fields_legal, m_tvalid, (mon != 4'd0) && (mon <= MONTH_DEC) && (dy != 5'd0) && (wd <= 3'd6) && (yd != 9'd0))
  `DAD_ASSERT_NOW(a_year_end_day, m_tvalid && (mon == MONTH_DEC) && (dy == DAY_LAST_DEC), (yd == 9'd365) || (yd == 9'd366))

  // s_tdata is visible for debug only.
  logic unused_in;
  assign unused_in = ^s_tdata;

endmodule

bind date_add_days_top dad_checker u_dad_checker (.*);

### verif/date_add_days_top_tb.sv
// Testbench for the date shifter: random and directed requests checked against a calendar model.
`timescale 1ns / 1ps

module date_add_days_top_tb;
  import dad_pkg::*;

  localparam int YEAR_FIRST = 1;
  localparam int YEAR_LAST = 9999;
  localparam int RANDOM_REQS = 1000;
  // Both the tail and the watchdog outlast the longest request.
  localparam int TAIL_CYCLES = 300;
  localparam int STALL_LIMIT = 5000;
  // The result receiver stops for a long stretch once this many dates have come back.
  localparam int LONG_HOLD_AT = 300;
  localparam int LONG_HOLD_CYCLES = 400;

  localparam int MONTH_DAYS[12] = '{31, 28, 31, 30, 31, 30, 31, 31, 30, 31, 30, 31};

  typedef struct {
    int  year;
    int  month;
    int  day;
    int  offset;
    int  gap;    // idle cycles before the request is offered
    bit  drain;  // hold the request until every pending date has come back
  } date_req_t;

  typedef struct packed {
    logic [YEAR_W-1:0]  year;
    logic [MONTH_W-1:0] month;
    logic [DAY_W-1:0]   day;
    logic [WDAY_W-1:0]  wday;
    logic [YDAY_W-1:0]  yday;
    logic               oor;
  } date_res_t;

  logic                clk = 1'b0;
  logic                rst = 1'b1;
  logic                s_tvalid = 1'b0;
  logic                s_tready;
  logic [S_DATA_W-1:0] s_tdata = '0;
  logic                m_tvalid;
  logic                m_tready = 1'b0;
  logic [M_DATA_W-1:0] m_tdata;

  date_req_t request_queue[$];
  date_res_t expected_dates[$];
  int        req_sent = 0;
  int        req_taken = 0;
  int        dates_seen = 0;
  int        fail_cnt = 0;
  int        gap_left = -1;
  int        stall_left = 0;
  int        seen_at_ready = 0;
  int        quiet_cycles = 0;

  date_add_days_top i_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Month length with the Gregorian leap rule; months outside 1..12 index the nearest end.
  function automatic int month_length(input int y, input int m);
    int  idx;
    bit  leap;
    idx = (m < 1) ? 0 : ((m > 12) ? 11 : m - 1);
    leap = ((y % 4 == 0) && (y % 100 != 0)) || (y % 400 == 0);
    return MONTH_DAYS[idx] + ((m == 2 && leap) ? 1 : 0);
  endfunction

  // Clamp the start date, walk whole months until the day fits, saturate the year,
  // then derive the day of the year and the weekday.
  function automatic date_res_t shift_date(input int y_in, input int m_in, input int d_in,
                                           input int n);
    int        y;
    int        m;
    int        d;
    int        yd;
    int        wy;
    int        wm;
    int        wd;
    int        i;
    bit        oor;
    date_res_t r;
    y = y_in;
    m = m_in;
    d = d_in;
    oor = 1'b0;
    if (y < YEAR_FIRST) begin
      y = YEAR_FIRST;
      oor = 1'b1;
    end
    if (y > YEAR_LAST) begin
      y = YEAR_LAST;
      oor = 1'b1;
    end
    if (m < 1) m = 1;
    if (m > 12) m = 12;
    if (d < 1) d = 1;
    if (d > month_length(y, m)) d = month_length(y, m);
    d += n;
    while (d > month_length(y, m)) begin
      d -= month_length(y, m);
      m++;
      if (m > 12) begin
        m = 1;
        y++;
      end
    end
    while (d < 1) begin
      m--;
      if (m < 1) begin
        m = 12;
        y--;
      end
      d += month_length(y, m);
    end
    if (y > YEAR_LAST) begin
      y = YEAR_LAST;
      m = 12;
      d = 31;
      oor = 1'b1;
    end
    if (y < YEAR_FIRST) begin
      y = YEAR_FIRST;
      m = 1;
      d = 1;
      oor = 1'b1;
    end
    yd = d;
    for (i = 1; i < m; i++) yd += month_length(y, i);
    // January and February count as months 13 and 14 of the year before.
    wy = y;
    wm = m;
    if (wm <= 2) begin
      wy--;
      wm += 12;
    end
    wd = (wy + wy / 4 - wy / 100 + wy / 400 + (13 * wm + 8) / 5 + d) % 7;
    r.year = y[YEAR_W-1:0];
    r.month = m[MONTH_W-1:0];
    r.day = d[DAY_W-1:0];
    r.wday = wd[WDAY_W-1:0];
    r.yday = yd[YDAY_W-1:0];
    r.oor = oor;
    return r;
  endfunction

  task automatic add_request(input int y, input int m, input int d, input int off,
                             input bit drain = 1'b0);
    date_req_t req;
    int        idx;
    idx = request_queue.size();
    req.year = y;
    req.month = m;
    req.day = d;
    req.offset = off;
    req.drain = drain;
    // One stretch of requests goes out back to back.
    req.gap = (idx >= 200 && idx < 300) ? 0 : $urandom_range(0, 11);
    request_queue.push_back(req);
  endtask

  task automatic report_field(input string field, input int want, input int got);
    if (want != got) begin
      $display("%0t: %s expected %0d, got %0d", $time, field, want, got);
      fail_cnt++;
    end
  endtask

  // Request driver: a request stays on the bus until it is taken, then the next one
  // waits out its gap. Changes land on the falling edge.
  always @(negedge clk) begin : drive_requests
    logic [S_DATA_W-1:0] bits;
    date_req_t           req;
    if (rst) begin
      s_tvalid <= 1'b0;
    end else if (s_tvalid && req_taken != req_sent) begin
      // The current request has not been taken yet.
    end else if (request_queue.size() == 0) begin
      s_tvalid <= 1'b0;
    end else begin
      if (gap_left < 0) gap_left = request_queue[0].gap;
      if (gap_left > 0) begin
        gap_left--;
        s_tvalid <= 1'b0;
      end else if (request_queue[0].drain && expected_dates.size() != 0) begin
        s_tvalid <= 1'b0;
      end else begin
        req = request_queue.pop_front();
        bits = '0;
        bits[S_YEAR_LSB +: YEAR_W] = req.year[YEAR_W-1:0];
        bits[S_MONTH_LSB +: MONTH_W] = req.month[MONTH_W-1:0];
        bits[S_DAY_LSB +: DAYIN_W] = req.day[DAYIN_W-1:0];
        bits[S_OFF_LSB +: OFFSET_WIDTH] = req.offset[OFFSET_WIDTH-1:0];
        s_tdata <= bits;
        s_tvalid <= 1'b1;
        req_sent++;
        gap_left = -1;
      end
    end
  end

  // Result receiver: after each date it draws a stall, with two stretches of no stall
  // and one long hold-off that backs the block up into its request side.
  always @(negedge clk) begin : drive_ready
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      if (dates_seen != seen_at_ready) begin
        seen_at_ready = dates_seen;
        if (dates_seen == LONG_HOLD_AT) begin
          stall_left = LONG_HOLD_CYCLES;
        end else if ((dates_seen >= 100 && dates_seen < 200) ||
                     (dates_seen >= 700 && dates_seen < 800)) begin
          stall_left = 0;
        end else begin
          stall_left = $urandom_range(0, 11);
        end
      end
      if (stall_left > 0) begin
        stall_left--;
        m_tready <= 1'b0;
      end else begin
        m_tready <= 1'b1;
      end
    end
  end

  // Bus monitor: results are checked before a request of the same edge is predicted.
  always @(posedge clk) begin : watch_bus
    date_res_t want;
    date_res_t got;
    if (!rst) begin
      if (m_tvalid && m_tready) begin
        got.year = m_tdata[M_YEAR_LSB +: YEAR_W];
        got.month = m_tdata[M_MONTH_LSB +: MONTH_W];
        got.day = m_tdata[M_DAY_LSB +: DAY_W];
        got.wday = m_tdata[M_WDAY_LSB +: WDAY_W];
        got.yday = m_tdata[M_YDAY_LSB +: YDAY_W];
        got.oor = m_tdata[M_OOR_BIT];
        dates_seen++;
        if (expected_dates.size() == 0) begin
          $display("%0t: date %0d-%0d-%0d returned with no request pending", $time,
                   got.year, got.month, got.day);
          fail_cnt++;
        end else begin
          want = expected_dates.pop_front();
          report_field("year_out", int'(want.year), int'(got.year));
          report_field("month_out", int'(want.month), int'(got.month));
          report_field("day_out", int'(want.day), int'(got.day));
          report_field("weekday", int'(want.wday), int'(got.wday));
          report_field("year_day", int'(want.yday), int'(got.yday));
          report_field("out_of_range", int'(want.oor), int'(got.oor));
        end
      end
      if (s_tvalid && s_tready) begin
        expected_dates.push_back(shift_date(int'(s_tdata[S_YEAR_LSB +: YEAR_W]),
                                            int'(s_tdata[S_MONTH_LSB +: MONTH_W]),
                                            int'(s_tdata[S_DAY_LSB +: DAYIN_W]),
                                            int'($signed(s_tdata[S_OFF_LSB +: OFFSET_WIDTH]))));
        req_taken++;
      end
    end
  end

  // Watchdog: too many cycles in a row with no request or result taken means a hang.
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("%0t: no handshake for %0d cycles", $time, quiet_cycles);
      $display("tb: failure");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    int pick;
    int y;
    int off;
    // Directed requests: field extremes, clamping, leap rules and both saturations.
    add_request(2024, 2, 29, 0);
    add_request(1, 1, 1, -1);
    add_request(9999, 12, 31, 1);
    add_request(0, 6, 15, 0);
    add_request(16383, 15, 63, 0);
    add_request(2023, 0, 0, 10);
    add_request(2023, 13, 5, -5);
    add_request(2023, 14, 40, 0);
    add_request(2000, 2, 63, 0);
    add_request(1900, 2, 63, 1);
    add_request(2004, 2, 30, 0);
    add_request(2023, 4, 31, 0);
    add_request(2023, 12, 31, 1);
    add_request(2024, 1, 1, -1);
    add_request(1600, 2, 28, 1);
    add_request(1700, 2, 28, 1);
    add_request(2000, 1, 1, 65535);
    add_request(2000, 1, 1, -65536);
    add_request(9999, 12, 31, -65536);
    add_request(1, 1, 1, 65535);
    add_request(9900, 6, 1, 65535);
    add_request(100, 6, 1, -65536);
    add_request(0, 0, 0, -65536);
    add_request(16383, 15, 63, -1);
    add_request(10000, 1, 1, -365);
    // The first random request waits for every directed date to come back.
    for (int k = 0; k < RANDOM_REQS; k++) begin
      pick = $urandom_range(0, 99);
      if (pick < 15) begin
        // Raw noise over every bit of every field.
        add_request($urandom_range(0, 16383), $urandom_range(0, 15), $urandom_range(0, 63),
                    int'($urandom_range(0, 131071)) - 65536, k == 0 || k == 600);
      end else begin
        if (pick < 30) begin
          y = ($urandom_range(0, 1) != 0) ? $urandom_range(1, 250) : $urandom_range(9750, 9999);
        end else begin
          y = $urandom_range(YEAR_FIRST, YEAR_LAST);
        end
        // Mostly short moves; the long ones are what make the block slow.
        if (pick < 70) begin
          off = int'($urandom_range(0, 800)) - 400;
        end else if (pick < 85) begin
          off = int'($urandom_range(0, 8000)) - 4000;
        end else begin
          off = int'($urandom_range(0, 131071)) - 65536;
        end
        add_request(y, $urandom_range(1, 12), $urandom_range(1, 31), off,
                    k == 0 || k == 600);
      end
    end
    repeat (10) @(posedge clk);
    @(negedge clk) rst <= 1'b0;
    while (request_queue.size() != 0 || req_taken != req_sent || expected_dates.size() != 0)
      @(negedge clk);
    repeat (TAIL_CYCLES) @(negedge clk);
    if (fail_cnt == 0 && expected_dates.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
